// ===== src/spectrogram_magnitude_colorizer_unit_defines.svh =====
// Assertion shorthands for the colorizer checker.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef SPECTROGRAM_MAGNITUDE_COLORIZER_UNIT_DEFINES_SVH
`define SPECTROGRAM_MAGNITUDE_COLORIZER_UNIT_DEFINES_SVH

`define SMC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smc: implication violated");

`define SMC_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("smc: forbidden condition seen");

`endif

// ===== src/smc_pkg.sv =====
package smc_pkg;

	localparam int MAG_BITS_DEF      = 32;
	localparam int LOG_FRAC_BITS_DEF = 12;

	localparam int IN_W       = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int DB_W       = 16;
	localparam int RANGE_W    = 16;
	localparam int T_FRAC     = 16;
	localparam int T_W        = T_FRAC + 1;
	localparam int DIV_STEPS  = 2;
	localparam int COLOR_W    = 8;

	localparam logic signed [DB_W-1:0] FLOOR_MAX   = -16'sd256;
	localparam logic signed [DB_W-1:0] FLOOR_RESET = -16'sd20480;

	// 20*log10(2) in Q16.
	localparam logic [19:0] DB_PER_OCT = 20'd394566;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PEAK  = 2'd0,
		CFG_FLOOR = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic token;
		logic zero;
	} smc_tag_t;

endpackage

// ===== src/smc_log2_pipe.sv =====
module smc_log2_pipe #(
	parameter int MAG_BITS  = 32,
	parameter int FRAC_BITS = 12,
	localparam int PW       = $clog2(MAG_BITS),
	localparam int LG_W     = PW + FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smc_pkg::smc_tag_t   tag_i,
	input  logic [MAG_BITS-1:0] x_i,
	output smc_pkg::smc_tag_t   tag_o,
	output logic [LG_W-1:0]     lg_o
);
	import smc_pkg::*;

	localparam int NCH    = (MAG_BITS + 7) / 8;
	localparam int PAD_W  = NCH * 8;
	localparam int NORM_W = MAG_BITS + FRAC_BITS;
	localparam int M_W    = 31;

	// Stage 1: leading-one position inside each byte.
	logic [PAD_W-1:0]    x_pad;
	logic [NCH-1:0]      nz_nx;
	logic [2:0]          pos_nx [NCH];
	smc_tag_t            tag_s1;
	logic [MAG_BITS-1:0] x_s1;
	logic [NCH-1:0]      nz_s1;
	logic [2:0]          pos_s1 [NCH];

	always_comb begin
		x_pad = PAD_W'(x_i);
		for (int c = 0; c < NCH; c++) begin
			nz_nx[c]  = |x_pad[c*8 +: 8];
			pos_nx[c] = '0;
			for (int b = 0; b < 8; b++) begin
				if (x_pad[c*8+b]) begin
					pos_nx[c] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= x_i;
		nz_s1  <= nz_nx;
		pos_s1 <= pos_nx;
	end

	// Stage 2: pick the highest nonzero byte.
	logic [PW-1:0]       p_nx;
	smc_tag_t            tag_s2;
	logic [MAG_BITS-1:0] x_s2;
	logic [PW-1:0]       p_s2;

	always_comb begin
		p_nx = '0;
		for (int c = 0; c < NCH; c++) begin
			if (nz_s1[c]) begin
				p_nx = PW'(c * 8 + int'(pos_s1[c]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s2 <= x_s1;
		p_s2 <= p_nx;
	end

	// Stage 3: normalize so the leading one sits at the top and take the
	// fraction bits below it; seed the mantissa of the squaring recurrence.
	logic [PW-1:0]        shamt;
	logic [NORM_W-1:0]    norm;
	logic [FRAC_BITS-1:0] idx;
	logic [M_W-1:0]       m0;

	smc_tag_t             tag_sr  [FRAC_BITS+1];
	logic [M_W-1:0]       m_sr    [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_sr [FRAC_BITS+1];
	logic [PW-1:0]        p_sr    [FRAC_BITS+1];

	always_comb begin
		shamt = PW'(MAG_BITS - 1) - p_s2;
		norm  = {x_s2, {FRAC_BITS{1'b0}}} << shamt;
		idx   = norm[NORM_W-2 -: FRAC_BITS];
		m0    = M_W'({1'b1, idx}) << (30 - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sr[0] <= '0;
		end else begin
			tag_sr[0] <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_sr[0]    <= m0;
		frac_sr[0] <= '0;
		p_sr[0]    <= p_s2;
	end

	// One fraction bit per stage: square the mantissa and renormalize.
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_rec
		logic [2*M_W-1:0] sq;
		logic [M_W:0]     top;
		logic [M_W-1:0]   m_nx;
		logic             bit_nx;

		always_comb begin
			sq  = m_sr[k] * m_sr[k];
			top = sq[2*M_W-1:30];
			if (top[M_W]) begin
				m_nx   = top[M_W:1];
				bit_nx = 1'b1;
			end else begin
				m_nx   = top[M_W-1:0];
				bit_nx = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sr[k+1] <= '0;
			end else begin
				tag_sr[k+1] <= tag_sr[k];
			end
		end

		always_ff @(posedge clk) begin
			m_sr[k+1]    <= m_nx;
			frac_sr[k+1] <= {frac_sr[k][FRAC_BITS-2:0], bit_nx};
			p_sr[k+1]    <= p_sr[k];
		end
	end

	assign tag_o = tag_sr[FRAC_BITS];
	assign lg_o  = {p_sr[FRAC_BITS], frac_sr[FRAC_BITS]};

endmodule

// ===== src/smc_level.sv =====
module smc_level #(
	parameter int MAG_BITS  = 32,
	parameter int FRAC_BITS = 12,
	localparam int LG_W     = $clog2(MAG_BITS) + FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smc_pkg::smc_tag_t                   tag_i,
	input  logic [LG_W-1:0]                     lg_i,
	input  logic [LG_W-1:0]                     lg_peak,
	input  logic signed [smc_pkg::DB_W-1:0]     floor_eff,
	output logic                                valid_o,
	output logic [smc_pkg::RANGE_W-1:0]         u_o
);
	import smc_pkg::*;

	localparam int D_W  = LG_W + 1;
	localparam int PR_W = D_W + 21;
	localparam int SH   = FRAC_BITS + 8;

	// Stage 1: log2 difference times dB per octave.
	logic signed [D_W-1:0]  d;
	logic signed [PR_W-1:0] prod;
	logic                   valid_s1;
	logic                   zero_s1;
	logic signed [PR_W-1:0] prod_s1;

	always_comb begin
		d    = $signed({1'b0, lg_i}) - $signed({1'b0, lg_peak});
		prod = d * $signed({1'b0, DB_PER_OCT});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tag_i.valid && !tag_i.token;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		zero_s1 <= tag_i.zero;
	end

	// Stage 2: floor to Q8.8, clamp to [floor, 0] and offset by the range.
	logic signed [PR_W-1:0]  dbv;
	logic signed [PR_W-1:0]  fl_x;
	logic signed [PR_W-1:0]  dbc;
	logic signed [PR_W-1:0]  u_full;
	logic                    valid_s2;
	logic [RANGE_W-1:0]      u_s2;

	always_comb begin
		dbv  = prod_s1 >>> SH;
		fl_x = {{(PR_W-DB_W){floor_eff[DB_W-1]}}, floor_eff};
		if (zero_s1 || dbv < fl_x) begin
			dbc = fl_x;
		end else if (dbv > 0) begin
			dbc = '0;
		end else begin
			dbc = dbv;
		end
		u_full = dbc - fl_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		u_s2 <= u_full[RANGE_W-1:0];
	end

	assign valid_o = valid_s2;
	assign u_o     = u_s2;

endmodule

// ===== src/smc_div_pipe.sv =====
module smc_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_i,
	input  logic [smc_pkg::RANGE_W-1:0]  u_i,
	input  logic [smc_pkg::RANGE_W-1:0]  range_i,
	output logic                         valid_o,
	output logic [smc_pkg::T_W-1:0]      t_o
);
	import smc_pkg::*;

	localparam int NST = T_FRAC / DIV_STEPS;

	logic               valid_sd [NST+1];
	logic [RANGE_W-1:0] r_sd     [NST+1];
	logic [T_W-1:0]     q_sd     [NST+1];

	// The dividend never exceeds the divisor, so the integer bit is just
	// an equality test and the remainder starts below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd[0] <= 1'b0;
		end else begin
			valid_sd[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (u_i == range_i) begin
			r_sd[0] <= '0;
			q_sd[0] <= T_W'(1);
		end else begin
			r_sd[0] <= u_i;
			q_sd[0] <= '0;
		end
	end

	for (genvar j = 0; j < NST; j++) begin : g_div
		logic [RANGE_W-1:0] r_nx;
		logic [T_W-1:0]     q_nx;
		logic [RANGE_W:0]   r2;

		always_comb begin
			r_nx = r_sd[j];
			q_nx = q_sd[j];
			r2   = '0;
			for (int s = 0; s < DIV_STEPS; s++) begin
				r2 = {r_nx, 1'b0};
				if (r2 >= {1'b0, range_i}) begin
					r2   = r2 - {1'b0, range_i};
					q_nx = {q_nx[T_W-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[T_W-2:0], 1'b0};
				end
				r_nx = r2[RANGE_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[j+1] <= 1'b0;
			end else begin
				valid_sd[j+1] <= valid_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			r_sd[j+1] <= r_nx;
			q_sd[j+1] <= q_nx;
		end
	end

	assign valid_o = valid_sd[NST];
	assign t_o     = q_sd[NST];

endmodule

// ===== src/smc_colormap.sv =====
module smc_colormap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_i,
	input  logic [smc_pkg::T_W-1:0]      t_i,
	output logic                         valid_o,
	output logic [smc_pkg::COLOR_W-1:0]  blue,
	output logic [smc_pkg::COLOR_W-1:0]  green,
	output logic [smc_pkg::COLOR_W-1:0]  red
);
	import smc_pkg::*;

	localparam int Q_SH = T_FRAC - 2;
	localparam int F_W  = T_FRAC - 1;
	localparam logic [T_W-1:0] QUARTER = T_W'(1) << Q_SH;

	localparam logic [COLOR_W-1:0] STOP_R [5] = '{8'd0, 8'd80, 8'd210, 8'd250, 8'd255};
	localparam logic [COLOR_W-1:0] STOP_G [5] = '{8'd0, 8'd10, 8'd60, 8'd150, 8'd255};
	localparam logic [COLOR_W-1:0] STOP_B [5] = '{8'd0, 8'd100, 8'd70, 8'd30, 8'd180};

	function automatic logic [COLOR_W-1:0] interp(input logic [COLOR_W-1:0] lo,
			input logic [COLOR_W-1:0] hi, input logic [F_W-1:0] f);
		logic signed [23:0] base;
		logic signed [23:0] dlt;
		logic signed [23:0] num;
		base = $signed({2'b00, lo, 14'd0});
		dlt  = $signed({16'd0, hi}) - $signed({16'd0, lo});
		num  = base + dlt * $signed({9'd0, f});
		if (num < 0) begin
			return '0;
		end
		return num[21:14];
	endfunction

	// Stage 1: segment and offset inside it.
	logic [1:0]     seg_nx;
	logic [T_W-1:0] f_full;
	logic           valid_s1;
	logic [1:0]     seg_s1;
	logic [F_W-1:0] f_s1;

	always_comb begin
		if (t_i <= QUARTER) begin
			seg_nx = 2'd0;
		end else if (t_i <= 2 * QUARTER) begin
			seg_nx = 2'd1;
		end else if (t_i <= 3 * QUARTER) begin
			seg_nx = 2'd2;
		end else begin
			seg_nx = 2'd3;
		end
		f_full = t_i - (T_W'(seg_nx) << Q_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1 <= seg_nx;
		f_s1   <= f_full[F_W-1:0];
	end

	// Stage 2: interpolate each channel between its two stops.
	logic [2:0] lo_idx;
	logic [2:0] hi_idx;
	logic       valid_s2;

	always_comb begin
		lo_idx = {1'b0, seg_s1};
		hi_idx = lo_idx + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		red   <= interp(STOP_R[lo_idx], STOP_R[hi_idx], f_s1);
		green <= interp(STOP_G[lo_idx], STOP_G[hi_idx], f_s1);
		blue  <= interp(STOP_B[lo_idx], STOP_B[hi_idx], f_s1);
	end

	assign valid_o = valid_s2;

endmodule

// ===== src/spectrogram_magnitude_colorizer_unit.sv =====
// Throughput: one magnitude per clock while no peak write holds busy high;
// depth is set by the log2 squaring chain, one stage per fraction bit,
// and the divider, two quotient bits per stage.
// busy is high only in a cycle that writes peak_magnitude; that slot carries the peak.
// Reset clears every valid bit and returns the registers to peak 1 and floor -80 dB.
// Results appear on done for one cycle; the receiver cannot hold them off.
module spectrogram_magnitude_colorizer_unit #(
	parameter int MAG_BITS      = smc_pkg::MAG_BITS_DEF,
	parameter int LOG_FRAC_BITS = smc_pkg::LOG_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [smc_pkg::IN_W-1:0]        magnitude,
	input  logic                            cfg_we,
	input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                            done,
	output logic [smc_pkg::COLOR_W-1:0]     blue,
	output logic [smc_pkg::COLOR_W-1:0]     green,
	output logic [smc_pkg::COLOR_W-1:0]     red,
	output logic [smc_pkg::COLOR_W-1:0]     alpha
);
	import smc_pkg::*;

	localparam int LG_W    = $clog2(MAG_BITS) + LOG_FRAC_BITS;
	localparam int EXT_W   = (MAG_BITS > IN_W) ? MAG_BITS : IN_W;
	localparam int LATENCY = 3 + LOG_FRAC_BITS + 2 + 1 + T_FRAC / DIV_STEPS + 2;

	logic                   peak_wr;
	logic [EXT_W-1:0]       mag_ext;
	logic [EXT_W-1:0]       peak_ext;
	logic [MAG_BITS-1:0]    mag_x;
	logic [MAG_BITS-1:0]    peak_x;
	logic [MAG_BITS-1:0]    x_in;
	smc_tag_t               tag_in;
	smc_tag_t               tag_lg;
	logic [LG_W-1:0]        lg;
	logic [LG_W-1:0]        lpeak_q;
	logic signed [DB_W-1:0] floor_q;
	logic signed [DB_W-1:0] floor_eff;
	logic [RANGE_W-1:0]     range;
	logic                   valid_lv;
	logic [RANGE_W-1:0]     u_lv;
	logic                   valid_dv;
	logic [T_W-1:0]         t_dv;

	// A peak write sends the new peak down the log2 pipeline in place of an
	// item; its log2 lands in lpeak_q ahead of every later transaction.
	assign peak_wr = cfg_we && (cfg_index == CFG_PEAK);
	assign busy    = peak_wr;

	always_comb begin
		mag_ext  = EXT_W'(magnitude);
		peak_ext = EXT_W'(cfg_wdata);
		mag_x    = mag_ext[MAG_BITS-1:0];
		peak_x   = (peak_ext[MAG_BITS-1:0] == '0) ? MAG_BITS'(1) : peak_ext[MAG_BITS-1:0];
		x_in         = peak_wr ? peak_x : mag_x;
		tag_in.valid = peak_wr || start;
		tag_in.token = peak_wr;
		tag_in.zero  = !peak_wr && (mag_x == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLOOR: begin
					floor_q <= cfg_wdata[DB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpeak_q <= '0;
		end else if (tag_lg.valid && tag_lg.token) begin
			lpeak_q <= lg;
		end
	end

	assign floor_eff = (floor_q > FLOOR_MAX) ? FLOOR_MAX : floor_q;
	assign range     = '0 - floor_eff;

	smc_log2_pipe #(
		.MAG_BITS  (MAG_BITS),
		.FRAC_BITS (LOG_FRAC_BITS)
	) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_i  (tag_in),
		.x_i    (x_in),
		.tag_o  (tag_lg),
		.lg_o   (lg)
	);

	smc_level #(
		.MAG_BITS  (MAG_BITS),
		.FRAC_BITS (LOG_FRAC_BITS)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_i     (tag_lg),
		.lg_i      (lg),
		.lg_peak   (lpeak_q),
		.floor_eff (floor_eff),
		.valid_o   (valid_lv),
		.u_o       (u_lv)
	);

	smc_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_lv),
		.u_i     (u_lv),
		.range_i (range),
		.valid_o (valid_dv),
		.t_o     (t_dv)
	);

	smc_colormap u_cmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_dv),
		.t_i     (t_dv),
		.valid_o (done),
		.blue    (blue),
		.green   (green),
		.red     (red)
	);

	assign alpha = 8'hFF;

endmodule

// ===== src/smc_checker.sv =====
`include "spectrogram_magnitude_colorizer_unit_defines.svh"

module smc_checker #(
	parameter int LATENCY = 1
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            cfg_we,
	input logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic                            done,
	input logic [smc_pkg::COLOR_W-1:0]     alpha
);
	import smc_pkg::*;

	// Every accepted transaction gives a pixel on done,
	// and no pixel shows up without one.
	`SMC_ASSERT_IMPLY(a_accept_gives_result, start && !busy, ##LATENCY done)
	`SMC_ASSERT_IMPLY(a_result_has_source, done, $past(start && !busy, LATENCY))
	`SMC_ASSERT_IMPLY(a_peak_write_blocks, cfg_we && cfg_index == CFG_PEAK, busy)
	`SMC_ASSERT_NEVER(a_alpha_opaque, done && alpha != 8'hFF)

endmodule

bind spectrogram_magnitude_colorizer_unit smc_checker #(
	.LATENCY (LATENCY)
) u_smc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.done      (done),
	.alpha     (alpha)
);
